### sv/gdate_pkg.sv
// Package for the Gregorian date shifter.
// Holds the year limit, the 400-year cycle constants, month codes, day and mode codes and the month length function.
// No dependencies.
package gdate_pkg;

  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [8:0]  CYCLE_YEARS = 9'd400;
  localparam logic [8:0]  CENTURY_1 = 9'd100;
  localparam logic [8:0]  CENTURY_2 = 9'd200;
  localparam logic [8:0]  CENTURY_3 = 9'd300;
  localparam logic [8:0]  CYCLE_LAST = 9'd399;

  localparam logic [3:0] MONTH_NONE = 4'd0;
  localparam logic [3:0] MONTH_JAN  = 4'd1;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [3:0] MONTH_MAR  = 4'd3;
  localparam logic [3:0] MONTH_APR  = 4'd4;
  localparam logic [3:0] MONTH_MAY  = 4'd5;
  localparam logic [3:0] MONTH_JUN  = 4'd6;
  localparam logic [3:0] MONTH_JUL  = 4'd7;
  localparam logic [3:0] MONTH_AUG  = 4'd8;
  localparam logic [3:0] MONTH_SEP  = 4'd9;
  localparam logic [3:0] MONTH_OCT  = 4'd10;
  localparam logic [3:0] MONTH_NOV  = 4'd11;
  localparam logic [3:0] MONTH_DEC  = 4'd12;

  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DEC_LAST_DAY = 5'd31;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_SUB = 1'b1;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### sv/gregorian_date_add_sub_days.sv
// Gregorian date shifter: moves a date forward or back by a day count,
// walking the calendar one month per clock cycle.
// Depends on gdate_pkg.
//
// One transaction at a time. After a transaction is taken, the block reduces
// the year modulo 400 for the leap rule by repeated subtraction, clamps the
// start day to the month length, and then walks month by month until the
// remaining count falls within the current month. The result is then held
// until it is taken, and only then is a new transaction accepted. Results
// leaving years 0..9999 saturate at the range limit and raise year_overflow.
module gregorian_date_add_sub_days (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic [15:0] in_day_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_result_year,
  output logic [3:0]  out_result_month,
  output logic [4:0]  out_result_day,
  output logic        out_year_overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CLAMP,
    S_WALK,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic        mode_r, mode_nxt;
  logic [13:0] y_r, y_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [4:0]  d_r, d_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [13:0] tmp_r, tmp_nxt;
  logic [8:0]  mod_r, mod_nxt;
  logic        ovf_r, ovf_nxt;
  logic        leap;
  logic [4:0]  len;
  logic [4:0]  rem;

  assign leap = (y_r[1:0] == 2'd0) && (mod_r != gdate_pkg::CENTURY_1)
                && (mod_r != gdate_pkg::CENTURY_2) && (mod_r != gdate_pkg::CENTURY_3);
  assign len = gdate_pkg::month_len(m_r, leap);
  assign rem = len - d_r;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    y_nxt     = y_r;
    m_nxt     = m_r;
    d_nxt     = d_r;
    cnt_nxt   = cnt_r;
    tmp_nxt   = tmp_r;
    mod_nxt   = mod_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          y_nxt = (in_start_year > gdate_pkg::YEAR_MAX) ? gdate_pkg::YEAR_MAX : in_start_year;
          tmp_nxt = y_nxt;
          if (in_start_month == gdate_pkg::MONTH_NONE) begin
            m_nxt = gdate_pkg::MONTH_JAN;
          end else if (in_start_month > gdate_pkg::MONTH_DEC) begin
            m_nxt = gdate_pkg::MONTH_DEC;
          end else begin
            m_nxt = in_start_month;
          end
          d_nxt = (in_start_day == 5'd0) ? gdate_pkg::DAY_FIRST : in_start_day;
          cnt_nxt = in_day_count;
          ovf_nxt = 1'b0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (tmp_r >= {5'd0, gdate_pkg::CYCLE_YEARS}) begin
          tmp_nxt = tmp_r - {5'd0, gdate_pkg::CYCLE_YEARS};
        end else begin
          mod_nxt = tmp_r[8:0];
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (d_r > len) begin
          d_nxt = len;
        end
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (mode_r == gdate_pkg::MODE_ADD) begin
          if (cnt_r <= {11'd0, rem}) begin
            d_nxt = d_r + cnt_r[4:0];
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r - ({11'd0, rem} + 16'd1);
            d_nxt = gdate_pkg::DAY_FIRST;
            if (m_r == gdate_pkg::MONTH_DEC) begin
              if (y_r == gdate_pkg::YEAR_MAX) begin
                d_nxt = gdate_pkg::DEC_LAST_DAY;
                ovf_nxt = 1'b1;
                state_nxt = S_DONE;
              end else begin
                y_nxt = y_r + 14'd1;
                m_nxt = gdate_pkg::MONTH_JAN;
                mod_nxt = (mod_r == gdate_pkg::CYCLE_LAST) ? 9'd0 : mod_r + 9'd1;
              end
            end else begin
              m_nxt = m_r + 4'd1;
            end
          end
        end else begin
          if (cnt_r < {11'd0, d_r}) begin
            d_nxt = d_r - cnt_r[4:0];
            state_nxt = S_DONE;
          end else begin
            cnt_nxt = cnt_r - {11'd0, d_r};
            if (m_r == gdate_pkg::MONTH_JAN) begin
              if (y_r == 14'd0) begin
                d_nxt = gdate_pkg::DAY_FIRST;
                ovf_nxt = 1'b1;
                state_nxt = S_DONE;
              end else begin
                y_nxt = y_r - 14'd1;
                m_nxt = gdate_pkg::MONTH_DEC;
                d_nxt = gdate_pkg::DEC_LAST_DAY;
                mod_nxt = (mod_r == 9'd0) ? gdate_pkg::CYCLE_LAST : mod_r - 9'd1;
              end
            end else begin
              m_nxt = m_r - 4'd1;
              d_nxt = gdate_pkg::month_len(m_r - 4'd1, leap);
            end
          end
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mode_r <= mode_nxt;
    y_r    <= y_nxt;
    m_r    <= m_nxt;
    d_r    <= d_nxt;
    cnt_r  <= cnt_nxt;
    tmp_r  <= tmp_nxt;
    mod_r  <= mod_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_result_year   = y_r;
  assign out_result_month  = m_r;
  assign out_result_day    = d_r;
  assign out_year_overflow = ovf_r;

  a_walk_cycle_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (mod_r < gdate_pkg::CYCLE_YEARS)
      && (mod_r[1:0] == y_r[1:0]))
    else $error("year cycle position out of step with year");

  a_result_sane : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_month >= gdate_pkg::MONTH_JAN)
      && (out_result_month <= gdate_pkg::MONTH_DEC)
      && (out_result_day >= gdate_pkg::DAY_FIRST)
      && (out_result_year <= gdate_pkg::YEAR_MAX))
    else $error("result date out of range");

  a_ovf_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_year_overflow) |->
      ((out_result_year == gdate_pkg::YEAR_MAX) && (out_result_month == gdate_pkg::MONTH_DEC)
        && (out_result_day == gdate_pkg::DEC_LAST_DAY))
      || ((out_result_year == 14'd0) && (out_result_month == gdate_pkg::MONTH_JAN)
        && (out_result_day == gdate_pkg::DAY_FIRST)))
    else $error("saturated result not at a range limit");

  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_result_day)
      && $stable(out_result_month) && $stable(out_result_year))
    else $error("pending result changed before it was taken");

endmodule

### tb/tb_gregorian_date_add_sub_days.sv
// Self-checking testbench for gregorian_date_add_sub_days.
// Holds its own calendar predictor, directed and random date stimulus, and a result checker.
// Depends on gdate_pkg and the gregorian_date_add_sub_days top level.
`timescale 1ns / 1ps

module tb_gregorian_date_add_sub_days;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        overflow;
  } date_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = gdate_pkg::MODE_ADD;
  logic [13:0] in_start_year = '0;
  logic [3:0]  in_start_month = gdate_pkg::MONTH_JAN;
  logic [4:0]  in_start_day = gdate_pkg::DAY_FIRST;
  logic [15:0] in_day_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] out_result_year;
  logic [3:0]  out_result_month;
  logic [4:0]  out_result_day;
  logic        out_year_overflow;

  date_result_t pending_dates[$];
  int unsigned  mismatch_count = 0;
  bit           idle_on = 1'b1;
  int unsigned  hold_off_cycles = 0;

  gregorian_date_add_sub_days u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_start_year     (in_start_year),
    .in_start_month    (in_start_month),
    .in_start_day      (in_start_day),
    .in_day_count      (in_day_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_year   (out_result_year),
    .out_result_month  (out_result_month),
    .out_result_day    (out_result_day),
    .out_year_overflow (out_year_overflow)
  );

  always #5 clk = ~clk;

  function automatic bit leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    if (m == gdate_pkg::MONTH_FEB) begin
      return leap(y) ? 29 : 28;
    end
    if (m == gdate_pkg::MONTH_APR || m == gdate_pkg::MONTH_JUN
        || m == gdate_pkg::MONTH_SEP || m == gdate_pkg::MONTH_NOV) begin
      return 30;
    end
    return 31;
  endfunction

  // Days in years 0 through y-1.
  function automatic int unsigned days_to_year(input int unsigned y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic date_result_t shift_date(input logic mode, input logic [13:0] year,
                                              input logic [3:0] month, input logic [4:0] day,
                                              input logic [15:0] count);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned n;
    int unsigned last_serial;
    date_result_t r;
    y = year;
    m = month;
    d = day;
    if (y > gdate_pkg::YEAR_MAX) y = gdate_pkg::YEAR_MAX;
    if (m < gdate_pkg::MONTH_JAN) m = gdate_pkg::MONTH_JAN;
    if (m > gdate_pkg::MONTH_DEC) m = gdate_pkg::MONTH_DEC;
    if (d < 1) d = 1;
    if (d > month_days(y, m)) d = month_days(y, m);
    n = days_to_year(y);
    for (int unsigned i = gdate_pkg::MONTH_JAN; i < m; i++) n += month_days(y, i);
    n += d - 1;
    last_serial = days_to_year(int'(gdate_pkg::YEAR_MAX) + 1) - 1;
    r.overflow = 1'b0;
    if (mode == gdate_pkg::MODE_ADD) begin
      n += count;
      if (n > last_serial) begin
        n = last_serial;
        r.overflow = 1'b1;
      end
    end else if (count > n) begin
      n = 0;
      r.overflow = 1'b1;
    end else begin
      n -= count;
    end
    y = (n * 400) / 146097;
    if (y > gdate_pkg::YEAR_MAX) y = gdate_pkg::YEAR_MAX;
    while (y < gdate_pkg::YEAR_MAX && days_to_year(y + 1) <= n) y++;
    while (y > 0 && days_to_year(y) > n) y--;
    n -= days_to_year(y);
    m = gdate_pkg::MONTH_JAN;
    while (m < gdate_pkg::MONTH_DEC && n >= month_days(y, m)) begin
      n -= month_days(y, m);
      m++;
    end
    r.year = 14'(y);
    r.month = 4'(m);
    r.day = 5'(n + 1);
    return r;
  endfunction

  task automatic report_mismatch(input bit has_want, input date_result_t want,
                                 input date_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (has_want) begin
        $display("mismatch: expected %0d-%0d-%0d ovf %0b, got %0d-%0d-%0d ovf %0b",
                 want.year, want.month, want.day, want.overflow,
                 got.year, got.month, got.day, got.overflow);
      end else begin
        $display("unexpected result %0d-%0d-%0d ovf %0b",
                 got.year, got.month, got.day, got.overflow);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    date_result_t got;
    date_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_result_year, out_result_month, out_result_day, out_year_overflow};
      if (pending_dates.size() == 0) begin
        report_mismatch(1'b0, '0, got);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) report_mismatch(1'b1, want, got);
      end
    end
  end

  initial begin : drive_out_ready
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles - 1) @(negedge clk);
        hold_off_cycles = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Returns just after the accepting edge; the next caller moves on at the falling edge.
  task automatic send_date(input logic mode, input int unsigned year, input int unsigned month,
                           input int unsigned day, input int unsigned count);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_start_year <= 14'(year);
    in_start_month <= 4'(month);
    in_start_day <= 5'(day);
    in_day_count <= 16'(count);
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back(shift_date(mode, 14'(year), 4'(month), 5'(day), 16'(count)));
  endtask

  task automatic send_random_date();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned count;
    int unsigned kind;
    int unsigned span;
    kind = $urandom_range(0, 19);
    y = $urandom_range(0, gdate_pkg::YEAR_MAX);
    m = $urandom_range(gdate_pkg::MONTH_JAN, gdate_pkg::MONTH_DEC);
    if (kind == 0) begin
      y = $urandom_range(0, 16383);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end else begin
      if (kind == 1) y = $urandom_range(gdate_pkg::YEAR_MAX - 9, gdate_pkg::YEAR_MAX);
      if (kind == 2) y = $urandom_range(0, 10);
      d = $urandom_range(1, month_days(y, m));
    end
    span = $urandom_range(0, 9);
    if (span < 2) count = $urandom_range(0, 65535);
    else if (span < 5) count = $urandom_range(0, 5000);
    else count = $urandom_range(0, 400);
    send_date($urandom_range(0, 1) ? gdate_pkg::MODE_SUB : gdate_pkg::MODE_ADD,
              y, m, d, count);
  endtask

  task automatic test_leap_rules();
    send_date(gdate_pkg::MODE_ADD, 2024, gdate_pkg::MONTH_FEB, 28, 1);
    send_date(gdate_pkg::MODE_ADD, 2023, gdate_pkg::MONTH_FEB, 28, 1);
    send_date(gdate_pkg::MODE_ADD, 2000, gdate_pkg::MONTH_FEB, 28, 1);
    send_date(gdate_pkg::MODE_ADD, 1900, gdate_pkg::MONTH_FEB, 28, 1);
    send_date(gdate_pkg::MODE_SUB, 2024, gdate_pkg::MONTH_MAR, 1, 1);
    send_date(gdate_pkg::MODE_ADD, 2023, gdate_pkg::MONTH_DEC, 31, 1);
    send_date(gdate_pkg::MODE_SUB, 2000, gdate_pkg::MONTH_JAN, 1, 366);
    send_date(gdate_pkg::MODE_ADD, 0, gdate_pkg::MONTH_FEB, 28, 1);
  endtask

  task automatic test_range_limits();
    send_date(gdate_pkg::MODE_ADD, gdate_pkg::YEAR_MAX, gdate_pkg::MONTH_DEC,
              gdate_pkg::DEC_LAST_DAY, 1);
    send_date(gdate_pkg::MODE_SUB, 0, gdate_pkg::MONTH_JAN, gdate_pkg::DAY_FIRST, 1);
    send_date(gdate_pkg::MODE_ADD, 0, gdate_pkg::MONTH_JAN, gdate_pkg::DAY_FIRST, 65535);
    send_date(gdate_pkg::MODE_SUB, gdate_pkg::YEAR_MAX, gdate_pkg::MONTH_DEC,
              gdate_pkg::DEC_LAST_DAY, 65535);
    send_date(gdate_pkg::MODE_ADD, gdate_pkg::YEAR_MAX, gdate_pkg::MONTH_JAN,
              gdate_pkg::DAY_FIRST, 65535);
    send_date(gdate_pkg::MODE_SUB, 5, gdate_pkg::MONTH_JUN, 15, 65535);
    send_date(gdate_pkg::MODE_ADD, 1234, gdate_pkg::MONTH_JUL, 4, 0);
    send_date(gdate_pkg::MODE_SUB, 8191, gdate_pkg::MONTH_AUG, 31, 0);
  endtask

  task automatic test_clamped_inputs();
    send_date(gdate_pkg::MODE_ADD, 16383, 15, 31, 0);
    send_date(gdate_pkg::MODE_SUB, 10000, gdate_pkg::MONTH_NONE, 0, 10);
    send_date(gdate_pkg::MODE_ADD, 2023, gdate_pkg::MONTH_APR, 31, 1);
    send_date(gdate_pkg::MODE_SUB, 2023, gdate_pkg::MONTH_FEB, 31, 0);
    send_date(gdate_pkg::MODE_ADD, 2024, gdate_pkg::MONTH_FEB, 30, 0);
    send_date(gdate_pkg::MODE_ADD, 2023, 13, 5, 20);
    send_date(gdate_pkg::MODE_ADD, gdate_pkg::YEAR_MAX, gdate_pkg::MONTH_DEC,
              gdate_pkg::DEC_LAST_DAY, 0);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 180; i++) begin
      idle_on = !(i >= 60 && i < 90);
      send_random_date();
    end
    idle_on = 1'b1;
  endtask

  // The receiver stalls longer than one full walk, so the held result blocks the input.
  task automatic test_output_backpressure();
    hold_off_cycles = 3000;
    send_date(gdate_pkg::MODE_ADD, 1999, gdate_pkg::MONTH_MAY, 17, 800);
    send_date(gdate_pkg::MODE_SUB, 4321, gdate_pkg::MONTH_OCT, 9, 1200);
    send_date(gdate_pkg::MODE_ADD, 2400, gdate_pkg::MONTH_FEB, 29, 300);
  endtask

  task automatic test_random_no_idle();
    idle_on = 1'b0;
    repeat (50) send_random_date();
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (2500) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_gregorian_date_add_sub_days: PASS");
    end else begin
      $display("tb_gregorian_date_add_sub_days: FAIL");
    end
    $finish;
  endtask

  initial begin : run_tests
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_leap_rules();
    test_range_limits();
    test_clamped_inputs();
    test_random_mix();
    test_output_backpressure();
    test_random_no_idle();
    finish_run();
  end

  initial begin : watchdog
    #30_000_000;
    $display("tb_gregorian_date_add_sub_days: FAIL");
    $finish;
  end

endmodule
